[sv/gtp_pkg.sv]
`timescale 1ns / 1ps

package gtp_pkg;

  localparam int unsigned GuidBytes      = 16;
  localparam int unsigned ByteCountWidth = 5;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_EARLY_END  = 2'd2
  } status_t;

  typedef struct packed {
    logic       eoi;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_blank;
    logic       is_hyphen;
    logic       is_lparen;
    logic       is_lcurly;
    logic       is_rparen;
    logic       is_rcurly;
  } token_t;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
    status_t     status;
  } result_t;

endpackage

[sv/gtp_front.sv]
`timescale 1ns / 1ps

module gtp_front import gtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output logic       tok_valid,
  output token_t     tok,
  input  logic       tok_pop
);

  token_t     tok_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  token_t     cls;

  // character classification
  always_comb begin
    cls           = '0;
    cls.eoi       = end_of_input;
    cls.is_blank  = (char_byte == 8'h20) || (char_byte >= 8'h09 && char_byte <= 8'h0d);
    cls.is_hyphen = (char_byte == 8'h2d);
    cls.is_lparen = (char_byte == 8'h28);
    cls.is_lcurly = (char_byte == 8'h7b);
    cls.is_rparen = (char_byte == 8'h29);
    cls.is_rcurly = (char_byte == 8'h7d);
    if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = char_byte[3:0];
    end else if ((char_byte >= 8'h61 && char_byte <= 8'h66) ||
                 (char_byte >= 8'h41 && char_byte <= 8'h46)) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = char_byte[3:0] + 4'd9;
    end
  end

  assign full      = (count == 2'd2);
  assign tok_valid = (count != 2'd0);
  assign push_ok   = push & ~full;
  assign tok       = tok_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      tok_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (tok_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push_ok} - {1'b0, tok_pop};
    end
  end

endmodule

[sv/gtp_back.sv]
`timescale 1ns / 1ps

module gtp_back import gtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_write,
  input  logic    cfg_data,
  input  logic    tok_valid,
  input  token_t  tok,
  output logic    tok_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_START  = 3'b001,
    PH_DIGITS = 3'b010,
    PH_CLOSE  = 3'b100
  } phase_t;

  logic                      skip_space;
  phase_t                    phase, phase_next;
  logic [ByteCountWidth-1:0] byte_count, byte_count_next;
  logic [3:0]                high_nibble, high_nibble_next;
  logic                      want_high, want_high_next;
  logic                      hyphen_mode, hyphen_mode_next;
  logic                      hyphen_taken, hyphen_taken_next;
  logic                      bracket_open, bracket_open_next;
  logic                      bracket_curly, bracket_curly_next;
  logic [7:0]                guid_bytes [GuidBytes];
  logic [7:0]                merged [GuidBytes];
  logic                      digit;
  logic                      byte_we;
  logic [7:0]                byte_val;
  status_t                   emit_status;

  assign tok_pop  = tok_valid & ~res_full;
  assign byte_val = {high_nibble, tok.hex_val};

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    high_nibble_next   = high_nibble;
    want_high_next     = want_high;
    hyphen_mode_next   = hyphen_mode;
    hyphen_taken_next  = hyphen_taken;
    bracket_open_next  = bracket_open;
    bracket_curly_next = bracket_curly;
    digit              = 1'b0;
    byte_we            = 1'b0;
    res_push           = 1'b0;
    emit_status        = ST_OK;

    if (tok_pop) begin
      if (tok.eoi) begin
        res_push    = 1'b1;
        emit_status = ST_EARLY_END;
      end else begin
        unique case (phase)
          PH_START: begin
            if (!(skip_space && tok.is_blank)) begin
              phase_next = PH_DIGITS;
              if (tok.is_lparen || tok.is_lcurly) begin
                bracket_open_next  = 1'b1;
                bracket_curly_next = tok.is_lcurly;
              end else begin
                digit = 1'b1;
              end
            end
          end
          PH_DIGITS: begin
            digit = 1'b1;
          end
          PH_CLOSE: begin
            res_push = 1'b1;
            if (bracket_curly ? tok.is_rcurly : tok.is_rparen) begin
              emit_status = ST_OK;
            end else begin
              emit_status = ST_BAD_CHAR;
            end
          end
          default: ;
        endcase
      end
    end

    if (digit) begin
      if (!hyphen_mode && tok.is_hyphen && byte_count == ByteCountWidth'(4)) begin
        hyphen_mode_next = 1'b1;
      end else if (hyphen_mode && !hyphen_taken &&
                   (byte_count == ByteCountWidth'(6) || byte_count == ByteCountWidth'(8) ||
                    byte_count == ByteCountWidth'(10))) begin
        if (!tok.is_hyphen) begin
          res_push    = 1'b1;
          emit_status = ST_BAD_CHAR;
        end else begin
          hyphen_taken_next = 1'b1;
        end
      end else if (!tok.is_hex) begin
        res_push    = 1'b1;
        emit_status = ST_BAD_CHAR;
      end else if (want_high) begin
        high_nibble_next = tok.hex_val;
        want_high_next   = 1'b0;
      end else begin
        byte_we           = 1'b1;
        byte_count_next   = byte_count + ByteCountWidth'(1);
        want_high_next    = 1'b1;
        hyphen_taken_next = 1'b0;
        if (byte_count == ByteCountWidth'(GuidBytes - 1)) begin
          if (bracket_open) begin
            phase_next = PH_CLOSE;
          end else begin
            res_push    = 1'b1;
            emit_status = ST_OK;
          end
        end
      end
    end

    // any result restarts the parser
    if (res_push) begin
      phase_next         = PH_START;
      byte_count_next    = '0;
      high_nibble_next   = '0;
      want_high_next     = 1'b1;
      hyphen_mode_next   = 1'b0;
      hyphen_taken_next  = 1'b0;
      bracket_open_next  = 1'b0;
      bracket_curly_next = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < GuidBytes; i++) begin
      merged[i] = (byte_we && byte_count[3:0] == 4'(i)) ? byte_val : guid_bytes[i];
    end
    res.status = emit_status;
    res.upper  = '0;
    res.lower  = '0;
    if (emit_status == ST_OK) begin
      for (int i = 0; i < 8; i++) begin
        res.upper[63-8*i -: 8] = merged[i];
        res.lower[63-8*i -: 8] = merged[i+8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      guid_bytes[byte_count[3:0]] <= byte_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_space    <= 1'b1;
      phase         <= PH_START;
      byte_count    <= '0;
      high_nibble   <= '0;
      want_high     <= 1'b1;
      hyphen_mode   <= 1'b0;
      hyphen_taken  <= 1'b0;
      bracket_open  <= 1'b0;
      bracket_curly <= 1'b0;
    end else begin
      if (cfg_write) begin
        skip_space <= cfg_data;
      end
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      high_nibble   <= high_nibble_next;
      want_high     <= want_high_next;
      hyphen_mode   <= hyphen_mode_next;
      hyphen_taken  <= hyphen_taken_next;
      bracket_open  <= bracket_open_next;
      bracket_curly <= bracket_curly_next;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= ByteCountWidth'(GuidBytes))
    else $error("byte count beyond guid length");

  a_close_state: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CLOSE) |-> (byte_count == ByteCountWidth'(GuidBytes) && bracket_open))
    else $error("closing phase without full guid and open bracket");

  a_hyphen_taken: assert property (@(posedge clk) disable iff (rst)
    hyphen_taken |-> hyphen_mode)
    else $error("hyphen taken outside hyphen mode");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!res_full && tok_valid))
    else $error("result pushed into full queue or without a word");
`endif

endmodule

[sv/gtp_res_queue.sv]
`timescale 1ns / 1ps

module gtp_res_queue import gtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t    res_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop_ok;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_ok   = pop & ~empty;
  assign head     = res_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, res_push} - {1'b0, pop_ok};
    end
  end

endmodule

[sv/guid_text_parser_unit.sv]
`timescale 1ns / 1ps

// guid text parser
// input side is a queue: present char_byte / end_of_input and raise push;
// the word is taken at a clock edge with push high and full low.
// result side is a queue: while empty is low, guid_upper, guid_lower and
// status hold the oldest result; it is taken at an edge with pop high.
// one result comes per parsed guid, per bad character and per end_of_input;
// on failure both guid halves are zero and the parser restarts.
// cfg_write with cfg_data sets skip_leading_space; write it only when idle.
// a taken word waits in the word queue; its result is registered in the
// result queue; one word is parsed per cycle while that queue is not full.
// a two-word queue sits before the parse step and another after it, so a
// stalled receiver fills the result queue, then the word queue, then full.
// reset clears both queues, restarts the parser and sets skipping on.
module guid_text_parser_unit import gtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] guid_upper,
  output logic [63:0] guid_lower,
  output logic [1:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_data
);

  logic    tok_valid;
  token_t  tok;
  logic    tok_pop;
  logic    res_full;
  logic    res_push;
  result_t res;
  result_t head;

  gtp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .tok_pop      (tok_pop)
  );

  gtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  gtp_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign guid_upper = head.upper;
  assign guid_lower = head.lower;
  assign status     = head.status;

endmodule
